// ----- rtl/record_lock_version_table_macros.svh -----
// Assertion macros shared by the record table RTL
`ifndef RECORD_LOCK_VERSION_TABLE_MACROS_SVH
`define RECORD_LOCK_VERSION_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define RLVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define RLVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rlvt_pkg.sv -----
package rlvt_pkg;

    localparam int KEY_W   = 32;
    localparam int WHO_W   = 16;
    localparam int DATA_W  = 64;
    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = KEY_W + WHO_W + 2 * DATA_W;
    localparam int M_DATA_W = 2 * DATA_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ     = 3'd0,
        FN_VALIDATE = 3'd1,
        FN_LOCK     = 3'd2,
        FN_FREE     = 3'd3,
        FN_WRITE    = 3'd4
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_REFUSED = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_LOOK,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic              locked;
        logic [WHO_W-1:0]  owner;
        logic [DATA_W-1:0] version;
        logic [DATA_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic in_ready;
        logic clear_en;
        logic div_step;
        logic mem_rd;
        logic exec;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_last;
        logic out_free;
    } t_ctrl_sts;

endpackage

// ----- rtl/rlvt_div.sv -----
module rlvt_div #(
    parameter int NODE_COUNT = 8
) (
    input  logic                      i_clk,
    input  logic                      i_start,
    input  logic                      i_step,
    input  logic [rlvt_pkg::KEY_W-1:0] i_key,
    output logic [rlvt_pkg::KEY_W-1:0] o_quot,
    output logic                      o_last
);

    localparam int SHIFT  = $clog2(NODE_COUNT);
    localparam int PROD_W = 2 * rlvt_pkg::KEY_W + 1;
    localparam logic [63:0] SCALE = 64'd1 << (rlvt_pkg::KEY_W + SHIFT);
    localparam logic [rlvt_pkg::KEY_W:0] RECIP =
        (rlvt_pkg::KEY_W + 1)'((SCALE + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT));

    logic [rlvt_pkg::KEY_W-1:0] r_num;
    logic [rlvt_pkg::KEY_W-1:0] r_quot;
    logic [PROD_W-1:0]          prod;

    // scale by the rounded-up reciprocal; exact over the whole key range
    assign prod = PROD_W'(r_num) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_key;
        end
        if (i_step) begin
            r_quot <= rlvt_pkg::KEY_W'(prod >> (rlvt_pkg::KEY_W + SHIFT));
        end
    end

    assign o_quot = r_quot;
    assign o_last = 1'b1;

endmodule

// ----- rtl/rlvt_datapath.sv -----
module rlvt_datapath #(
    parameter int ENTRIES    = 4096,
    parameter int NODE_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rlvt_pkg::t_ctrl_cmd           i_cmd,
    output rlvt_pkg::t_ctrl_sts           o_sts,
    input  logic                          i_s_tvalid,
    input  logic [rlvt_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [rlvt_pkg::FUNC_W-1:0]   i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [rlvt_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [rlvt_pkg::STAT_W-1:0]   o_m_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int KW    = rlvt_pkg::KEY_W;
    localparam int WW    = rlvt_pkg::WHO_W;
    localparam int DW    = rlvt_pkg::DATA_W;

    rlvt_pkg::t_entry mem [ENTRIES];

    logic                          load;
    logic [KW-1:0]                 quot;
    logic                          div_last;
    logic [rlvt_pkg::FUNC_W-1:0]   r_func;
    logic [WW-1:0]                 r_who;
    logic [DW-1:0]                 r_exp;
    logic [DW-1:0]                 r_nval;
    logic [IDX_W-1:0]              r_idx;
    logic                          r_in_range;
    logic [IDX_W-1:0]              r_clr_addr;
    rlvt_pkg::t_entry              r_rd;
    rlvt_pkg::t_entry              n_entry;
    rlvt_pkg::t_status             n_status;
    logic                          upd;
    logic                          mem_we;
    logic [IDX_W-1:0]              mem_waddr;
    rlvt_pkg::t_entry              mem_wdata;
    logic                          r_out_valid;
    logic                          n_out_valid;
    rlvt_pkg::t_status             r_out_status;
    logic [DW-1:0]                 r_out_value;
    logic [DW-1:0]                 r_out_version;

    assign load = i_cmd.in_ready & i_s_tvalid;

    rlvt_div #(
        .NODE_COUNT (NODE_COUNT)
    ) u_div (
        .i_clk   (i_clk),
        .i_start (load),
        .i_step  (i_cmd.div_step),
        .i_key   (i_s_tdata[KW-1:0]),
        .o_quot  (quot),
        .o_last  (div_last)
    );

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_func <= i_s_tuser;
            r_who  <= i_s_tdata[KW +: WW];
            r_exp  <= i_s_tdata[KW + WW +: DW];
            r_nval <= i_s_tdata[KW + WW + DW +: DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // look up the entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_idx      <= quot[IDX_W-1:0];
            r_in_range <= quot < KW'(ENTRIES);
            r_rd       <= mem[quot[IDX_W-1:0]];
        end
    end

    always_comb begin
        n_entry  = r_rd;
        n_status = rlvt_pkg::STAT_OK;
        upd      = 1'b0;
        case (rlvt_pkg::t_func'(r_func))
            rlvt_pkg::FN_READ: begin
                n_status = rlvt_pkg::STAT_OK;
            end
            rlvt_pkg::FN_VALIDATE: begin
                if (r_rd.version != r_exp) begin
                    n_status = rlvt_pkg::STAT_REFUSED;
                end
            end
            rlvt_pkg::FN_LOCK: begin
                if (!r_rd.locked) begin
                    n_entry.locked = 1'b1;
                    n_entry.owner  = r_who;
                    upd            = 1'b1;
                end else if (r_rd.owner != r_who) begin
                    n_status = rlvt_pkg::STAT_REFUSED;
                end
            end
            rlvt_pkg::FN_FREE: begin
                if (r_rd.locked && r_rd.owner == r_who) begin
                    n_entry.locked = 1'b0;
                    upd            = 1'b1;
                end else begin
                    n_status = rlvt_pkg::STAT_REFUSED;
                end
            end
            rlvt_pkg::FN_WRITE: begin
                n_entry.version = r_rd.version + 1'b1;
                n_entry.value   = r_nval;
                upd             = 1'b1;
            end
            default: begin
                n_status = rlvt_pkg::STAT_REFUSED;
            end
        endcase
    end

    assign mem_we    = i_cmd.clear_en | (i_cmd.exec & r_in_range & upd);
    assign mem_waddr = i_cmd.clear_en ? r_clr_addr : r_idx;
    assign mem_wdata = i_cmd.clear_en ? '0 : n_entry;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign n_out_valid = i_cmd.exec | (r_out_valid & ~i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_in_range) begin
                r_out_status  <= n_status;
                r_out_value   <= n_entry.value;
                r_out_version <= n_entry.version;
            end else begin
                r_out_status  <= rlvt_pkg::STAT_RANGE;
                r_out_value   <= '0;
                r_out_version <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_version, r_out_value};
    assign o_m_tuser  = r_out_status;

    assign o_sts.clear_last = r_clr_addr == IDX_W'(ENTRIES - 1);
    assign o_sts.div_last   = div_last;
    assign o_sts.out_free   = ~r_out_valid | i_m_tready;

endmodule

// ----- rtl/rlvt_ctrl.sv -----
module rlvt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  rlvt_pkg::t_ctrl_sts i_sts,
    output rlvt_pkg::t_ctrl_cmd o_cmd
);

    rlvt_pkg::t_state r_state;
    rlvt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlvt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rlvt_pkg::S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = rlvt_pkg::S_IDLE;
                end
            end
            rlvt_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = rlvt_pkg::S_DIV;
                end
            end
            rlvt_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = rlvt_pkg::S_LOOK;
                end
            end
            rlvt_pkg::S_LOOK: begin
                n_state = rlvt_pkg::S_EXEC;
            end
            rlvt_pkg::S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = rlvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rlvt_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            rlvt_pkg::S_CLEAR: o_cmd.clear_en = 1'b1;
            rlvt_pkg::S_IDLE:  o_cmd.in_ready = 1'b1;
            rlvt_pkg::S_DIV:   o_cmd.div_step = 1'b1;
            rlvt_pkg::S_LOOK:  o_cmd.mem_rd   = 1'b1;
            rlvt_pkg::S_EXEC:  o_cmd.exec     = i_sts.out_free;
            default:           o_cmd          = '0;
        endcase
    end

endmodule

// ----- rtl/record_lock_version_table.sv -----
// Record table with per-entry value, version and owner lock.
// Slave channel: one request word per handshake; tuser carries the function
// (read, validate, lock, free, write), tdata the key, requester, expected
// version and new value. Master channel: one result word per request; tuser
// carries the status, tdata the entry's value and version after the update.
// The entry index is the key divided by NODE_COUNT, taken by multiplying
// with a rounded-up reciprocal in one registered step.
// The request, its quotient, the table entry and then the result are each
// registered in turn. A request passes the accepting state, the reciprocal
// multiply, a table read and a read-modify-write before the next is taken.
// Reset: a clearing pass writes every entry to zero in address order,
// with tready low throughout.
// Stall: the result sits in an output register, so the next request is
// taken while it waits; its update then holds until that register frees.
`include "record_lock_version_table_macros.svh"

module record_lock_version_table #(
    parameter int ENTRIES    = 4096,
    parameter int NODE_COUNT = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // key[31:0], requester[47:32], expected_version[111:48], new_value[175:112]
    input  logic [rlvt_pkg::S_DATA_W-1:0] i_s_tdata,
    // func[2:0]
    input  logic [rlvt_pkg::FUNC_W-1:0]   i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // record_value[63:0], record_version[127:64]
    output logic [rlvt_pkg::M_DATA_W-1:0] o_m_tdata,
    // status[1:0]
    output logic [rlvt_pkg::STAT_W-1:0]   o_m_tuser
);

    rlvt_pkg::t_ctrl_cmd cmd;
    rlvt_pkg::t_ctrl_sts sts;

    rlvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rlvt_datapath #(
        .ENTRIES    (ENTRIES),
        .NODE_COUNT (NODE_COUNT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    assign o_s_tready = cmd.in_ready;

    `RLVT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "second word taken while busy")
    `RLVT_ASSERT_NOW(a_no_take_in_clear, i_clk, i_rst_n, cmd.clear_en, !o_s_tready && !cmd.exec, "word taken during clearing pass")
    `RLVT_ASSERT_NOW(a_range_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == rlvt_pkg::STAT_RANGE, o_m_tdata == '0, "out-of-range word carries data")

endmodule
